// ----- sv/assert_macros.svh -----
// Assertion macros used by the sorted key/value table RTL (the sequencer skvt_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SKVT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SKVT_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKVT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKVT_ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/skvt_pkg.sv -----
// Types, codes and constants of the sorted key/value table.
package skvt_pkg;

    localparam int ENTRIES_DEF = 256;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int MAXE_W = 9;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [KEY_W-1:0] ALL_ONES = '1;
    localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 9'd256;
    localparam logic [PADDR_W-1:0] ADDR_MAX_ENTRIES = 3'd0;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_QUERY = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_PICK = 3'd3;
    localparam logic [2:0] OP_ADV = 3'd4;

    localparam logic [2:0] ST_NEW = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_FOUND = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_PAIR = 3'd5;
    localparam logic [2:0] ST_ENDED = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SHIFT,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic             load;
        logic             shift;
        logic             commit_new;
        logic             commit_upd;
        logic             pick;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cell_cmd;

    typedef struct packed {
        logic             lt;
        logic             hit;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] res_key;
        logic [VAL_W-1:0] res_value;
    } t_cell_link;

endpackage

// ----- sv/skvt_if.sv -----
// Request and response channel interfaces of the sorted key/value table.
interface skvt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] lba;
    logic [31:0] offset;

    modport source (output valid, operation, lba, offset, input ready);
    modport sink (input valid, operation, lba, offset, output ready);
endinterface

interface skvt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] out_lba;
    logic [31:0] out_offset;
    logic        done_res;

    modport source (output valid, status, out_lba, out_offset, done_res, input ready);
    modport sink (input valid, status, out_lba, out_offset, done_res, output ready);
endinterface

// ----- sv/skvt_cell.sv -----
// One cell of the sorted chain: a stored pair plus one stage of the result chain.
module skvt_cell
    import skvt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX = 0
) (
    input  logic                           i_clk,
    input  t_cell_cmd                      i_cmd,
    input  logic [$clog2(ENTRIES+1)-1:0]   i_count,
    input  logic [$clog2(ENTRIES+1)-1:0]   i_pos,
    input  t_cell_link                     i_left,
    output t_cell_link                     o_link
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic             r_hit;
    logic [KEY_W-1:0] r_res_key;
    logic [VAL_W-1:0] r_res_val;

    logic w_valid;
    logic w_lt;
    logic w_eq;
    logic w_sel;
    logic w_room;

    always_comb begin
        w_valid = MY_IDX < i_count;
        w_lt = w_valid && (r_key < i_cmd.key);
        w_eq = w_valid && (r_key == i_cmd.key);
        w_sel = i_cmd.pick ? (w_valid && (i_pos == MY_IDX)) : w_eq;
        w_room = MY_IDX <= i_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit <= w_sel;
            r_res_key <= r_key;
            r_res_val <= r_val;
        end else if (i_cmd.shift && !r_hit) begin
            r_hit <= i_left.hit;
            r_res_key <= i_left.res_key;
            r_res_val <= i_left.res_value;
        end
    end

    // On a new-pair commit, the left neighbor's order flag decides whether this cell
    // takes the new pair, moves up by one place, or keeps what it holds.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_upd && w_eq) begin
            r_val <= i_cmd.value;
        end else if (i_cmd.commit_new && w_room) begin
            if (!w_lt && i_left.lt) begin
                r_key <= i_cmd.key;
                r_val <= i_cmd.value;
            end else if (!i_left.lt) begin
                r_key <= i_left.key;
                r_val <= i_left.value;
            end
        end
    end

    assign o_link = '{lt: w_lt, hit: r_hit, key: r_key, value: r_val,
                      res_key: r_res_key, res_value: r_res_val};

endmodule

// ----- sv/skvt_ctrl.sv -----
// Sequencer of the sorted key/value table: operation decode, counts and result register.
`include "assert_macros.svh"
module skvt_ctrl
    import skvt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [MAXE_W-1:0]             i_max_entries,
    skvt_req_if.sink                      i_req,
    skvt_rsp_if.source                    o_rsp,
    input  t_cell_link                    i_tail,
    output t_cell_cmd                     o_cmd,
    output logic [$clog2(ENTRIES+1)-1:0]  o_count,
    output logic [$clog2(ENTRIES+1)-1:0]  o_pos
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = $clog2(ENTRIES);
    localparam int EW = (CW > MAXE_W) ? CW : MAXE_W;
    localparam logic [SW-1:0] SHIFT_LAST = SW'(ENTRIES - 2);

    t_state           r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic [KEY_W-1:0] r_lba, n_lba;
    logic [VAL_W-1:0] r_off, n_off;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_pos, n_pos;
    logic             r_fin, n_fin;
    logic             r_full, n_full;
    logic             r_end, n_end;
    logic [SW-1:0]    r_shift, n_shift;
    logic             r_ovalid, n_ovalid;
    logic [2:0]       r_ostatus, n_ostatus;
    logic [KEY_W-1:0] r_olba, n_olba;
    logic [VAL_W-1:0] r_ooff, n_ooff;
    logic             r_odone, n_odone;

    logic          w_iter;
    logic [CW-1:0] w_pos_eff;
    logic          w_end;
    logic          w_full;
    logic          w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_pos <= '0;
            r_fin <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_pos <= n_pos;
            r_fin <= n_fin;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_lba <= n_lba;
        r_off <= n_off;
        r_full <= n_full;
        r_end <= n_end;
        r_shift <= n_shift;
        r_ostatus <= n_ostatus;
        r_olba <= n_olba;
        r_ooff <= n_ooff;
        r_odone <= n_odone;
    end

    always_comb begin
        w_iter = (r_op == OP_START) || (r_op == OP_PICK) || (r_op == OP_ADV);
        case (r_op)
            OP_START: w_pos_eff = '0;
            OP_ADV:   w_pos_eff = (r_pos < r_cnt) ? r_pos + 1'b1 : r_pos;
            default:  w_pos_eff = r_pos;
        endcase
        w_end = w_pos_eff >= r_cnt;
        w_full = (EW'(r_cnt) >= EW'(ENTRIES)) || (EW'(r_cnt) >= EW'(i_max_entries));
        w_out_free = !r_ovalid || o_rsp.ready;
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_lba = r_lba;
        n_off = r_off;
        n_cnt = r_cnt;
        n_pos = r_pos;
        n_fin = r_fin;
        n_full = r_full;
        n_end = r_end;
        n_shift = r_shift;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_ostatus = r_ostatus;
        n_olba = r_olba;
        n_ooff = r_ooff;
        n_odone = r_odone;
        o_cmd = '{load: 1'b0, shift: 1'b0, commit_new: 1'b0, commit_upd: 1'b0,
                  pick: w_iter, key: r_lba, value: r_off};
        i_req.ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_op = i_req.operation;
                    n_lba = i_req.lba;
                    n_off = i_req.offset;
                    case (i_req.operation) inside
                        [OP_INSERT:OP_ADV]: n_state = S_LOAD;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_full = w_full;
                n_end = w_end;
                n_shift = '0;
                if (w_iter) begin
                    n_pos = w_pos_eff;
                    n_fin = ((r_op == OP_START) ? 1'b0 : r_fin) | w_end;
                end
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (r_shift == SHIFT_LAST) begin
                    n_state = S_COMMIT;
                end else begin
                    n_shift = r_shift + 1'b1;
                end
            end
            S_COMMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_olba = ALL_ONES;
                    n_ooff = ALL_ONES;
                    n_odone = r_fin;
                    case (r_op)
                        OP_INSERT: begin
                            if (r_full) begin
                                n_ostatus = ST_FULL;
                            end else if (i_tail.hit) begin
                                n_ostatus = ST_UPDATED;
                                n_ooff = i_tail.res_value;
                                o_cmd.commit_upd = 1'b1;
                            end else begin
                                n_ostatus = ST_NEW;
                                o_cmd.commit_new = 1'b1;
                                n_cnt = r_cnt + 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            if (i_tail.hit) begin
                                n_ostatus = ST_FOUND;
                                n_ooff = i_tail.res_value;
                            end else begin
                                n_ostatus = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (r_end) begin
                                n_ostatus = ST_ENDED;
                            end else begin
                                n_ostatus = ST_PAIR;
                                n_olba = i_tail.res_key;
                                n_ooff = i_tail.res_value;
                            end
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_count = r_cnt;
    assign o_pos = w_pos_eff;

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.status = r_ostatus;
    assign o_rsp.out_lba = r_olba;
    assign o_rsp.out_offset = r_ooff;
    assign o_rsp.done_res = r_odone;

    `SKVT_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(ENTRIES), "pair count exceeds table size")
    `SKVT_ASSERT(a_pos_bound, i_clk, i_rst_n, r_pos <= r_cnt, "iterator beyond pair count")
    `SKVT_ASSERT(a_cnt_step, i_clk, i_rst_n, (r_cnt != $past(r_cnt)) |-> ($past(r_state) == S_COMMIT && r_cnt == $past(r_cnt) + 1'b1), "pair count changed outside an insert commit")
    `SKVT_ASSERT(a_load_shift, i_clk, i_rst_n, (r_state == S_LOAD) |=> (r_state == S_SHIFT), "load not followed by result shifting")
    `SKVT_ASSERT_CLK(a_rsp_origin, i_clk, $rose(r_ovalid) |-> ($past(r_state) == S_COMMIT && $past(i_rst_n)), "response raised outside commit")

endmodule

// ----- sv/sorted_key_value_table.sv -----
// Top level of the sorted key/value table: register port, sequencer and chain of cells.
//
//   channel  | direction | handshake          | payload
//   i_req    | in        | valid/ready        | operation, lba, offset
//   o_rsp    | out       | valid/ready        | status, out_lba, out_offset, done_res
//   APB      | in/out    | psel/penable/pready| max_entries at address 0
//
// Every operation loads the result chain in S_LOAD, lets the hit ripple along the cells in
// S_SHIFT and commits in S_COMMIT, where its result enters the output register; the next
// request is taken only back in S_IDLE, after that commit.
// Unknown operations are accepted and give no result.
// Reset is synchronous and empties the table; the pair storage itself is not cleared.
// A stalled result waits in the output register while the next request is taken;
// the commit of that next request waits until the output register is free.
module sorted_key_value_table
    import skvt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    skvt_req_if.sink            i_req,
    skvt_rsp_if.source          o_rsp
);

    localparam int CW = $clog2(ENTRIES + 1);

    logic [MAXE_W-1:0] r_max_entries;
    t_cell_cmd         w_cmd;
    logic [CW-1:0]     w_count;
    logic [CW-1:0]     w_pos;
    t_cell_link        w_link [ENTRIES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_ENTRIES) begin
            r_max_entries <= pwdata[MAXE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_ENTRIES) ? PDATA_W'(r_max_entries) : '0;

    assign w_link[0] = '{lt: 1'b1, hit: 1'b0, key: '0, value: '0, res_key: '0, res_value: '0};

    skvt_ctrl #(
        .ENTRIES(ENTRIES)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_max_entries(r_max_entries),
        .i_req(i_req),
        .o_rsp(o_rsp),
        .i_tail(w_link[ENTRIES]),
        .o_cmd(w_cmd),
        .o_count(w_count),
        .o_pos(w_pos)
    );

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        skvt_cell #(
            .ENTRIES(ENTRIES),
            .IDX(g)
        ) u_cell (
            .i_clk(i_clk),
            .i_cmd(w_cmd),
            .i_count(w_count),
            .i_pos(w_pos),
            .i_left(w_link[g]),
            .o_link(w_link[g+1])
        );
    end

endmodule
